// ===== src/csfb_pkg.sv =====
`default_nettype none
package csfb_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

	typedef enum logic [2:0] {
		MODE_ADD   = 3'd0,
		MODE_SUB   = 3'd1,
		MODE_RAISE = 3'd2,
		MODE_LOWER = 3'd3,
		MODE_SET   = 3'd4
	} mode_t;

	// polynomial coefficients of the quarter cosine, Q16
	localparam logic [10:0] COS_K1 = 11'd1367;
	localparam logic [5:0]  COS_K0 = 6'd60;
	localparam logic [14:0] COS_K2 = 15'd16624;
	localparam logic [16:0] COS_K3 = 17'd80852;
	localparam logic [17:0] COS_ONE = 18'd65536;

	localparam logic [9:0]  CENTER_RST = 10'd0;
	localparam logic [15:0] EXTENT_RST = 16'd640;
	localparam logic [14:0] GAIN_RST   = 15'd3277;

endpackage
`default_nettype wire

// ===== src/cosine_falloff_height_brush.sv =====
`default_nettype none
// Cosine-falloff height brush. Each transaction presents one height-map sample
// (cell_x, cell_y, old_height). done pulses for one cycle with new_height and
// changed. A new sample may be started in every cycle; busy is always low and
// the result cannot be held off, so the receiver must take it in that cycle.
// The pipeline holds two entry stages, 18 square-root stages (one root bit
// each), 17 stages of the distance/extent divider (an overflow check, then one
// quotient bit each), 5 stages of the cosine polynomial, one gain multiply and
// one mode stage. Configuration is written through cfg_we/cfg_addr/cfg_wdata
// and must only change while no sample is in flight.
module cosine_falloff_height_brush #(
	parameter int MAP_SIDE = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [8:0]  cell_x,
	input  wire logic [8:0]  cell_y,
	input  wire logic signed [15:0] old_height,
	output logic             done,
	output logic signed [15:0] new_height,
	output logic             changed,
	input  wire logic        cfg_we,
	input  wire logic [csfb_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [csfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import csfb_pkg::*;

	localparam int SB_W = 17;

	// configuration registers
	logic [8:0]  center_x_q, center_y_q;
	logic [15:0] extent_q;
	logic [14:0] gain_q;
	logic [2:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RST[8:0];
			center_y_q <= CENTER_RST[8:0];
			extent_q   <= EXTENT_RST;
			gain_q     <= GAIN_RST;
			mode_q     <= MODE_ADD;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CENTER_X: center_x_q <= cfg_wdata[8:0];
				REG_CENTER_Y: center_y_q <= cfg_wdata[8:0];
				REG_EXTENT:   extent_q   <= cfg_wdata;
				REG_GAIN:     gain_q     <= cfg_wdata[14:0];
				REG_MODE:     mode_q     <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// no backpressure: a transaction is accepted whenever start is high
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: offsets from the centre and window test
	logic signed [9:0]  dx, dy;
	logic signed [10:0] rad, dxe, dye;
	logic               on_map, in_win;

	assign dx  = signed'({1'b0, cell_x} - {1'b0, center_x_q});
	assign dy  = signed'({1'b0, cell_y} - {1'b0, center_y_q});
	assign dxe = {dx[9], dx};
	assign dye = {dy[9], dy};
	assign rad = signed'({1'b0, extent_q[15:6]});
	assign on_map = ({23'd0, cell_x} < 32'(MAP_SIDE)) && ({23'd0, cell_y} < 32'(MAP_SIDE));
	// extent below one cell gives rad = 0 and an empty window
	assign in_win = on_map && (dxe >= -rad) && (dxe < rad) && (dye >= -rad) && (dye < rad);

	logic               vld_s1, vld_s2;
	logic signed [9:0]  dx_s1, dy_s1;
	logic               inside_s1, inside_s2;
	logic signed [15:0] h_s1, h_s2;
	logic [19:0]        d2_s2;

	logic signed [19:0] sqx, sqy;
	assign sqx = 20'(dx_s1) * 20'(dx_s1);
	assign sqy = 20'(dy_s1) * 20'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1     <= dx;
		dy_s1     <= dy;
		inside_s1 <= in_win;
		h_s1      <= old_height;
		// stage 2: squared distance, exact
		d2_s2     <= unsigned'(sqx) + unsigned'(sqy);
		inside_s2 <= inside_s1;
		h_s2      <= h_s1;
	end

	// distance in Q.8
	logic            sq_vld;
	logic [17:0]     sq_root;
	logic [SB_W-1:0] sq_sb;

	csfb_isqrt #(.SB_W(SB_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.in_val   ({d2_s2, 16'd0}),
		.in_sb    ({inside_s2, h_s2}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_sb   (sq_sb)
	);

	// distance / extent in Q16
	logic            dv_vld;
	logic [15:0]     dv_t;
	logic            dv_ovf;
	logic [SB_W-1:0] dv_sb;

	csfb_div #(.SB_W(SB_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.extent  (extent_q),
		.in_vld  (sq_vld),
		.in_dq   (sq_root),
		.in_sb   (sq_sb),
		.out_vld (dv_vld),
		.out_t   (dv_t),
		.out_ovf (dv_ovf),
		.out_sb  (dv_sb)
	);

	logic              cs_vld;
	logic [16:0]       cs_c;
	logic [SB_W:0]     cs_sb;

	csfb_cos #(.SB_W(SB_W+1)) u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dv_vld),
		.in_t    (dv_t),
		.in_sb   ({dv_ovf, dv_sb}),
		.out_vld (cs_vld),
		.out_c   (cs_c),
		.out_sb  (cs_sb)
	);

	// delta stage: gain scaling; beyond the extent delta is zero
	logic [31:0]        gprod;
	logic               vld_s3;
	logic               inside_s3;
	logic signed [15:0] h_s3;
	logic [15:0]        delta_s3;

	assign gprod = cs_c * gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= cs_vld;
		end
	end

	always_ff @(posedge clk) begin
		inside_s3 <= cs_sb[SB_W-1];
		h_s3      <= cs_sb[15:0];
		delta_s3  <= cs_sb[SB_W] ? 16'd0 : gprod[31:16];
	end

	// mode stage
	logic signed [17:0] hx, dlx, sum, dif;
	logic signed [15:0] nh;

	assign hx  = 18'(h_s3);
	assign dlx = signed'({2'b00, delta_s3});
	assign sum = hx + dlx;
	assign dif = hx - dlx;

	always_comb begin
		nh = h_s3;
		if (inside_s3 && (delta_s3 != 16'd0)) begin
			case (mode_q)
				MODE_ADD:   if (sum < 18'sd32768) nh = sum[15:0];
				MODE_SUB:   if (dif > -18'sd32768) nh = dif[15:0];
				MODE_RAISE: if (hx < dlx) nh = delta_s3;
				MODE_LOWER: if (hx > -dlx) nh = 16'(-dlx);
				MODE_SET:   nh = delta_s3;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		new_height <= nh;
		changed    <= nh != h_s3;
	end

	a_valid_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |=> done)
		else $error("result strobe missing after mode stage");

	a_outside_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !inside_s3) |=> !changed)
		else $error("sample outside window was altered");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && gain_q == 15'd0) |=> !changed)
		else $error("zero gain altered a sample");

endmodule
`default_nettype wire

// ===== src/csfb_isqrt.sv =====
`default_nettype none
// Pipelined digit-by-digit square root, one result bit per stage.
module csfb_isqrt #(
	parameter int SB_W = 17
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	input  wire logic [35:0]     in_val,
	input  wire logic [SB_W-1:0] in_sb,
	output logic                 out_vld,
	output logic [17:0]          out_root,
	output logic [SB_W-1:0]      out_sb
);
	localparam int STEPS = 18;

	logic            vld_s [0:STEPS];
	logic [36:0]     v_s   [0:STEPS];
	logic [36:0]     res_s [0:STEPS];
	logic [SB_W-1:0] sb_s  [0:STEPS];

	assign vld_s[0] = in_vld;
	assign v_s[0]   = {1'b0, in_val};
	assign res_s[0] = '0;
	assign sb_s[0]  = in_sb;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [36:0] BIT = 37'(1) << (34 - 2*i);
		logic [36:0] trial;
		assign trial = res_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[i+1] <= sb_s[i];
			if (v_s[i] >= trial) begin
				v_s[i+1]   <= v_s[i] - trial;
				res_s[i+1] <= (res_s[i] >> 1) + BIT;
			end else begin
				v_s[i+1]   <= v_s[i];
				res_s[i+1] <= res_s[i] >> 1;
			end
		end
	end

	assign out_vld  = vld_s[STEPS];
	assign out_root = res_s[STEPS][17:0];
	assign out_sb   = sb_s[STEPS];
endmodule
`default_nettype wire

// ===== src/csfb_div.sv =====
`default_nettype none
// t = floor(dq * 2^14 / extent), 16 quotient bits, one bit per stage.
// ovf flags t >= 2^16.
module csfb_div #(
	parameter int SB_W = 17
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [15:0]     extent,
	input  wire logic            in_vld,
	input  wire logic [17:0]     in_dq,
	input  wire logic [SB_W-1:0] in_sb,
	output logic                 out_vld,
	output logic [15:0]          out_t,
	output logic                 out_ovf,
	output logic [SB_W-1:0]      out_sb
);
	localparam int STEPS = 16;

	logic            vld_s [0:STEPS];
	logic [15:0]     rem_s [0:STEPS];
	logic [15:0]     lo_s  [0:STEPS];
	logic [15:0]     q_s   [0:STEPS];
	logic            ovf_s [0:STEPS];
	logic [SB_W-1:0] sb_s  [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= in_dq[17:2];
		lo_s[0]  <= {in_dq[1:0], 14'd0};
		q_s[0]   <= '0;
		ovf_s[0] <= in_dq >= {extent, 2'b00};
		sb_s[0]  <= in_sb;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [16:0] x;
		logic [16:0] diff;
		assign x    = {rem_s[i], lo_s[i][15]};
		assign diff = x - {1'b0, extent};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			lo_s[i+1]  <= {lo_s[i][14:0], 1'b0};
			ovf_s[i+1] <= ovf_s[i];
			sb_s[i+1]  <= sb_s[i];
			if (x >= {1'b0, extent}) begin
				rem_s[i+1] <= diff[15:0];
				q_s[i+1]   <= {q_s[i][14:0], 1'b1};
			end else begin
				rem_s[i+1] <= x[15:0];
				q_s[i+1]   <= {q_s[i][14:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[STEPS];
	assign out_t   = q_s[STEPS];
	assign out_ovf = ovf_s[STEPS];
	assign out_sb  = sb_s[STEPS];
endmodule
`default_nettype wire

// ===== src/csfb_cos.sv =====
`default_nettype none
// Quarter cosine cos(pi/2 * t), Q16 in and out, Horner form, one product per stage.
module csfb_cos #(
	parameter int SB_W = 18
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	input  wire logic [15:0]     in_t,
	input  wire logic [SB_W-1:0] in_sb,
	output logic                 out_vld,
	output logic [16:0]          out_c,
	output logic [SB_W-1:0]      out_sb
);
	import csfb_pkg::*;

	logic            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [SB_W-1:0] sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [15:0]     z_s1, z_s2, z_s3, z_s4;
	logic [10:0]     q1_s2;
	logic [14:0]     q2_s3;
	logic [16:0]     q3_s4;
	logic [16:0]     c_s5;

	logic [31:0] tt;
	logic [21:0] p0;
	logic [26:0] p1;
	logic [30:0] p2;
	logic [32:0] p3;
	logic signed [17:0] cdiff;

	assign tt    = in_t * in_t;
	assign p0    = z_s1 * COS_K0;
	assign p1    = z_s2 * q1_s2;
	assign p2    = z_s3 * q2_s3;
	assign p3    = z_s4 * q3_s4;
	assign cdiff = signed'(COS_ONE - {1'b0, p3[32:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= tt[31:16];
		sb_s1 <= in_sb;
		z_s2  <= z_s1;
		q1_s2 <= COS_K1 - {5'd0, p0[21:16]};
		sb_s2 <= sb_s1;
		z_s3  <= z_s2;
		q2_s3 <= COS_K2 - {4'd0, p1[26:16]};
		sb_s3 <= sb_s2;
		z_s4  <= z_s3;
		q3_s4 <= COS_K3 - {2'd0, p2[30:16]};
		sb_s4 <= sb_s3;
		sb_s5 <= sb_s4;
		if (cdiff < 0) begin
			c_s5 <= '0;
		end else begin
			c_s5 <= cdiff[16:0];
		end
	end

	assign out_vld = vld_s5;
	assign out_c   = c_s5;
	assign out_sb  = sb_s5;
endmodule
`default_nettype wire
